[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/rmget_pkg.sv]
`default_nettype none
package rmget_pkg;
  localparam int unsigned HdrLimit = 9;
  localparam logic [15:0] CapReset = 16'd16370;
  localparam logic [7:0] ChStar = 8'h5C;
  localparam logic [7:0] ChDollar = 8'h5B;
  localparam logic [7:0] ChComma = 8'h6B;
  localparam logic [7:0] ChMinus = 8'h60;
  localparam logic [7:0] ChPlus = 8'h4E;
  localparam logic [7:0] ChCr = 8'h0D;
  localparam logic [7:0] ChLf = 8'h25;
  localparam logic [29:0] ValueCap = 30'h3FFF_FFFF;

  typedef enum logic [1:0] {
    ST_FOUND = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_reply;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  out_byte;
    logic [1:0]  status;
    logic [15:0] entry_total;
    logic        end_of_results;
  } out_item_t;

  // front to back: up to two results for one input byte
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_item_t r0;
    out_item_t r1;
  } pair_t;

  localparam int QDepth = 4;
  localparam int QAw = 2;
endpackage
`default_nettype wire

[hw/rtl/rmget_front.sv]
`default_nettype none
module rmget_front
  import rmget_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire in_item_t    item,
  input  wire logic [15:0] cap,
  output pair_t            res
);
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    P_ARRAY, P_COUNT, P_DOLLAR, P_LEN, P_DATA, P_DCR, P_DLF, P_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  flen_r, flen_nxt;
  logic [29:0] fval_r, fval_nxt;
  logic        fneg_r, fneg_nxt, dend_r, dend_nxt, crs_r, crs_nxt, nst_r, nst_nxt;
  logic [29:0] decl_r, decl_nxt, left_r, left_nxt;
  logic [15:0] done_r, done_nxt, wr_r, wr_nxt;
  logic        copy_r, copy_nxt;

  logic [7:0]  b;
  logic        fdone, cmt_ok, do_cr, do_b;
  logic [33:0] mul;
  logic [29:0] cv_val;
  logic        cv_neg, cv_de, cv_ns;
  logic [3:0]  cv_len;
  pair_t       res_nxt;

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h40 || c == 8'h05 || c == 8'h0B || c == 8'h0C ||
           c == 8'h0D || c == 8'h15 || c == 8'h25;
  endfunction

  function automatic out_item_t stat_item(input logic [1:0] st, input logic [15:0] cnt);
    out_item_t o;
    o.item_kind = 1'b1;
    o.out_byte = 8'd0;
    o.status = st;
    o.entry_total = (st == ST_ERROR) ? 16'd0 : cnt;
    o.end_of_results = 1'b1;
    return o;
  endfunction

  function automatic out_item_t text_item(input logic [7:0] c);
    out_item_t o;
    o.item_kind = 1'b0;
    o.out_byte = c;
    o.status = 2'd0;
    o.entry_total = 16'd0;
    o.end_of_results = 1'b0;
    return o;
  endfunction

  always_comb begin
    logic [7:0] c;
    logic       ok;
    logic [15:0] dn;
    b = item.in_byte;
    phase_nxt = phase_r;
    flen_nxt = flen_r; fval_nxt = fval_r; fneg_nxt = fneg_r;
    dend_nxt = dend_r; crs_nxt = crs_r; nst_nxt = nst_r;
    decl_nxt = decl_r; left_nxt = left_r; done_nxt = done_r;
    wr_nxt = wr_r; copy_nxt = copy_r;
    res_nxt = '0;
    fdone = 1'b0; cmt_ok = 1'b1;
    do_cr = 1'b0; do_b = 1'b0;
    mul = '0; cv_val = fval_r; cv_neg = fneg_r; cv_de = dend_r; cv_ns = nst_r;
    cv_len = flen_r; c = b; ok = 1'b1; dn = done_r;

    // field byte handling, computed for count and length phases
    if (crs_r && b == ChLf) begin
      fdone = 1'b1;
    end else begin
      if (crs_r) do_cr = 1'b1;
      if (b != ChCr) do_b = 1'b1;
    end
    // generic commit sequence (up to two)
    for (int k = 0; k < 2; k++) begin
      if ((k == 0 && do_cr) || (k == 1 && do_b)) begin
        c = (k == 0) ? ChCr : b;
        if (ok) begin
          if (cv_len == 4'(HdrLimit)) begin
            ok = 1'b0;
          end else begin
            cv_len = cv_len + 4'd1;
            if (!cv_de) begin
              if (c >= 8'hF0 && c <= 8'hF9) begin
                mul = {4'd0, cv_val} * 34'd10 + {30'd0, c[3:0]};
                cv_val = (mul > {4'd0, ValueCap}) ? ValueCap : mul[29:0];
                cv_ns = 1'b1;
              end else if (cv_ns) begin
                cv_de = 1'b1;
              end else if (is_space(c)) begin
                cv_ns = cv_ns;
              end else if (c == ChMinus || c == ChPlus) begin
                cv_neg = (c == ChMinus);
                cv_ns = 1'b1;
              end else begin
                cv_de = 1'b1;
              end
            end
          end
        end
      end
    end
    cmt_ok = ok;

    if (take) begin
      unique case (phase_r)
        P_ARRAY: begin
          if (b == ChStar) begin
            flen_nxt = '0; fval_nxt = '0; fneg_nxt = 1'b0; dend_nxt = 1'b0;
            crs_nxt = 1'b0; nst_nxt = 1'b0; phase_nxt = P_COUNT;
          end else begin
            res_nxt.v0 = 1'b1; res_nxt.r0 = stat_item(ST_ERROR, 16'd0);
            phase_nxt = P_DONE;
          end
        end
        P_COUNT, P_LEN: begin
          flen_nxt = cv_len; fval_nxt = cv_val; fneg_nxt = cv_neg;
          dend_nxt = cv_de; nst_nxt = cv_ns;
          crs_nxt = !fdone && (b == ChCr);
          if (!fdone && !cmt_ok) begin
            res_nxt.v0 = 1'b1; res_nxt.r0 = stat_item(ST_ERROR, 16'd0);
            phase_nxt = P_DONE;
          end else if (fdone && phase_r == P_COUNT) begin
            if (fneg_r || fval_r == '0) begin
              res_nxt.v0 = 1'b1; res_nxt.r0 = stat_item(ST_EMPTY, done_r);
              phase_nxt = P_DONE;
            end else begin
              decl_nxt = fval_r; phase_nxt = P_DOLLAR;
            end
          end else if (fdone) begin
            if (fneg_r && fval_r != '0) begin
              if (fval_r == 30'd1) begin
                dn = done_r + 16'd1;
                done_nxt = dn;
                if ({14'd0, dn} >= decl_r || {1'b0, wr_r} + 17'd1 >= {1'b0, cap}) begin
                  res_nxt.v0 = 1'b1;
                  res_nxt.r0 = stat_item((dn != 0) ? ST_FOUND : ST_EMPTY, dn);
                  phase_nxt = P_DONE;
                end else begin
                  phase_nxt = P_DOLLAR;
                end
              end else begin
                res_nxt.v0 = 1'b1; res_nxt.r0 = stat_item(ST_ERROR, 16'd0);
                phase_nxt = P_DONE;
              end
            end else begin
              left_nxt = fval_r;
              copy_nxt = ({15'd0, wr_r} + {1'b0, fval_r}) < {15'd0, cap};
              phase_nxt = (fval_r == '0) ? P_DCR : P_DATA;
            end
          end
        end
        P_DOLLAR: begin
          if (b == ChDollar) begin
            if (done_r != '0) begin
              res_nxt.v0 = 1'b1; res_nxt.r0 = text_item(ChComma);
              wr_nxt = wr_r + 16'd1;
            end
            flen_nxt = '0; fval_nxt = '0; fneg_nxt = 1'b0; dend_nxt = 1'b0;
            crs_nxt = 1'b0; nst_nxt = 1'b0; phase_nxt = P_LEN;
          end else begin
            res_nxt.v0 = 1'b1; res_nxt.r0 = stat_item(ST_ERROR, 16'd0);
            phase_nxt = P_DONE;
          end
        end
        P_DATA: begin
          if (copy_r) begin
            res_nxt.v0 = 1'b1; res_nxt.r0 = text_item(b);
            wr_nxt = wr_r + 16'd1;
          end
          left_nxt = left_r - 30'd1;
          if (left_r == 30'd1) phase_nxt = P_DCR;
        end
        P_DCR: begin
          if (b == ChCr) begin
            phase_nxt = P_DLF;
          end else begin
            res_nxt.v0 = 1'b1; res_nxt.r0 = stat_item(ST_ERROR, 16'd0);
            phase_nxt = P_DONE;
          end
        end
        P_DLF: begin
          if (b != ChLf) begin
            res_nxt.v0 = 1'b1; res_nxt.r0 = stat_item(ST_ERROR, 16'd0);
            phase_nxt = P_DONE;
          end else if (!copy_r) begin
            res_nxt.v0 = 1'b1;
            res_nxt.r0 = stat_item((done_r != 0) ? ST_FOUND : ST_EMPTY, done_r);
            phase_nxt = P_DONE;
          end else begin
            dn = done_r + 16'd1;
            done_nxt = dn;
            if ({14'd0, dn} >= decl_r || {1'b0, wr_r} + 17'd1 >= {1'b0, cap}) begin
              res_nxt.v0 = 1'b1;
              res_nxt.r0 = stat_item((dn != 0) ? ST_FOUND : ST_EMPTY, dn);
              phase_nxt = P_DONE;
            end else begin
              phase_nxt = P_DOLLAR;
            end
          end
        end
        P_DONE: begin
          phase_nxt = P_DONE;
        end
        default: begin
          phase_nxt = P_ARRAY;
        end
      endcase
      if (item.end_of_reply) begin
        if (phase_nxt != P_DONE) begin
          if (res_nxt.v0) begin
            res_nxt.v1 = 1'b1; res_nxt.r1 = stat_item(ST_ERROR, 16'd0);
          end else begin
            res_nxt.v0 = 1'b1; res_nxt.r0 = stat_item(ST_ERROR, 16'd0);
          end
        end
        phase_nxt = P_ARRAY;
        flen_nxt = '0; fval_nxt = '0; fneg_nxt = 1'b0; dend_nxt = 1'b0;
        crs_nxt = 1'b0; nst_nxt = 1'b0; decl_nxt = '0; done_nxt = '0;
        wr_nxt = '0; left_nxt = '0; copy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_ARRAY;
      flen_r <= '0; fval_r <= '0; fneg_r <= 1'b0; dend_r <= 1'b0;
      crs_r <= 1'b0; nst_r <= 1'b0; decl_r <= '0; done_r <= '0;
      wr_r <= '0; left_r <= '0; copy_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      flen_r <= flen_nxt; fval_r <= fval_nxt; fneg_r <= fneg_nxt; dend_r <= dend_nxt;
      crs_r <= crs_nxt; nst_r <= nst_nxt; decl_r <= decl_nxt; done_r <= done_nxt;
      wr_r <= wr_nxt; left_r <= left_nxt; copy_r <= copy_nxt;
    end
  end

  assign res = res_nxt;

  `ASSERT_IMPL(a_v1_needs_v0, clk, rst_n, take && res_nxt.v1, res_nxt.v0)
  `ASSERT_NEXT(a_eor_rearms, clk, rst_n, take && item.end_of_reply, phase_r == P_ARRAY)
  `ASSERT_IMPL(a_len_bound, clk, rst_n, 1'b1, flen_r <= 4'(HdrLimit))
endmodule
`default_nettype wire

[hw/rtl/rmget_queue.sv]
`default_nettype none
module rmget_queue
  import rmget_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire pair_t     wr,
  input  wire logic      wr_en,
  output logic           room,
  output out_item_t      rd,
  output logic           rd_empty,
  input  wire logic      rd_pop
);
  `include "assert_macros.svh"

  out_item_t        mem_r [QDepth];
  logic [QAw-1:0]   wp_r, rp_r;
  logic [QAw:0]     cnt_r;
  logic [1:0]       nin;
  logic             pop;

  assign nin = (wr_en && wr.v0) ? (wr.v1 ? 2'd2 : 2'd1) : 2'd0;
  assign rd_empty = (cnt_r == '0);
  assign pop = rd_pop && !rd_empty;
  assign rd = mem_r[rp_r];
  // keep space for two entries from the front
  assign room = (cnt_r <= (QAw+1)'(QDepth - 2));

  always_ff @(posedge clk) begin
    if (nin != 2'd0) mem_r[wp_r] <= wr.r0;
    if (nin == 2'd2) mem_r[wp_r + QAw'(1)] <= wr.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_r + QAw'(nin);
      if (pop) rp_r <= rp_r + QAw'(1);
      cnt_r <= cnt_r + (QAw+1)'(nin) - (QAw+1)'(pop);
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst_n, 1'b1, cnt_r <= (QAw+1)'(QDepth))
endmodule
`default_nettype wire

[hw/rtl/resp_mget_reply_to_csv.sv]
// key-value array reply to comma separated text
// input channel: push in_item (byte, end_of_reply) while full is low; one byte
//   per cycle is accepted as long as the result queue has room for two entries
// result channel: out_item is valid while out_empty is low, taken with out_pop;
//   text items carry value bytes and commas, a status item closes each reply
// config: cfg_wr_en with cfg_wr_data sets output capacity; the user must write it only when idle, not enforced here
// results: a result is written into the result queue in the cycle after the byte that causes it
// throughput: one input byte per cycle; each byte gives at most two results,
//   so the queue of four entries sets the figure when the reader is slower
// reset (synchronous, rst_n low): parser awaits the array marker, queue is
//   empty, capacity returns to 16370
// when the receiver stalls the queue fills and full rises, holding the input
`default_nettype none
module resp_mget_reply_to_csv
  import rmget_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire in_item_t    in_item,
  output logic             out_empty,
  input  wire logic        out_pop,
  output out_item_t        out_item,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);
  logic [15:0] cap_r;
  logic        room, take;
  pair_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CapReset;
    else if (cfg_wr_en) cap_r <= cfg_wr_data;
  end

  assign in_full = !room;
  assign take = in_push && room;

  rmget_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .item(in_item), .cap(cap_r), .res(res)
  );

  rmget_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr(res), .wr_en(take), .room(room),
    .rd(out_item), .rd_empty(out_empty), .rd_pop(out_pop)
  );
endmodule
`default_nettype wire
